// ----- sv/rxas_pkg.sv -----
// ----------------------------------------------------------------------------
// rxas_pkg
// Types and constants shared by the RX anomaly score block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rxas_pkg;

   localparam logic [1:0] FUNC_MEAN   = 2'd0;
   localparam logic [1:0] FUNC_COV    = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam int DIFF_W  = 21;
   localparam int MEAN_W  = 20;
   localparam int COEF_W  = 32;
   localparam int SCORE_W = 48;
   localparam int BC_W    = 6;
   localparam logic [BC_W-1:0] BC_RESET = 6'd32;

   typedef struct packed {
      logic [1:0]         func;
      logic [4:0]         row_index;
      logic [4:0]         col_index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DIAG,
      ST_MAC,
      ST_DRAIN,
      ST_MLO,
      ST_MHI,
      ST_SUM,
      ST_ACC,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ----- sv/rxas_ram.sv -----
// ----------------------------------------------------------------------------
// rxas_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rxas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// ----- sv/rxas_cell.sv -----
// ----------------------------------------------------------------------------
// rxas_cell
// One cell of the difference ring: holds one band difference and passes it on.
// ----------------------------------------------------------------------------
`default_nettype none

module rxas_cell (
   input  wire logic                              clock,
   input  wire rxas_pkg::cell_ctrl_type           ctrl,
   input  wire logic signed [rxas_pkg::DIFF_W-1:0] load_data,
   input  wire logic signed [rxas_pkg::DIFF_W-1:0] from_next,
   output logic      signed [rxas_pkg::DIFF_W-1:0] diff
);
   import rxas_pkg::*;

   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [DIFF_W-1:0] diff_in;

   always_comb begin
      diff_in = diff_ff;
      if (ctrl.load) begin
         diff_in = load_data;
      end else if (ctrl.shift) begin
         diff_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign diff = diff_ff;

endmodule

`default_nettype wire

// ----- sv/rx_anomaly_score.sv -----
// ----------------------------------------------------------------------------
// rx_anomaly_score
// Per-pixel RX (Mahalanobis) anomaly score over a hyperspectral cube.
// ----------------------------------------------------------------------------
// Mean and inverse covariance write words leave the block idle. A band sample
// occupies the block and stalls new requests (MAX_BANDS limited to 32):
// the band differences sit in a ring of cells that rotates once per sample
// past a single multiply-accumulate unit, which reads both mirrored matrix
// entries per cycle from the two read ports of the coefficient memory. The
// score word of the last band waits in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_anomaly_score #(
   parameter int MAX_BANDS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire rxas_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output rxas_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rxas_pkg::BC_W-1:0]         csr_data
);
   import rxas_pkg::*;

   localparam int NB = (MAX_BANDS < 32) ? MAX_BANDS : 32;
   localparam int RW = $clog2(NB);
   localparam int AW = $clog2(NB * NB);

   function automatic logic [AW-1:0] cov_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
      return AW'(32'(r) * NB + 32'(c));
   endfunction

   state_type state_ff, state_in;

   logic [BC_W-1:0]           bc_ff;
   logic [4:0]                k_ff;
   logic [15:0]               s_ff;
   logic signed [DIFF_W-1:0]  d_ff;
   logic [RW-1:0]             j_ff, j_in;
   logic signed [63:0]        t_ff, p_ff, v_ff, acc_ff;
   logic                      pv_ff, flag_ff;
   logic [63:0]               mlo_ff, mhi_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic                      req_take;
   logic [BC_W-1:0]           nb;
   logic [RW-1:0]             jn;
   logic [RW-1:0]             ra_r, ra_c;
   logic [RW-1:0]             mean_ra;
   logic [MEAN_W-1:0]         mean_rd;
   logic [COEF_W-1:0]         cov_rd_a, cov_rd_b;
   logic                      mean_we, cov_we;
   cell_ctrl_type             cell_ctrl [NB];
   logic signed [DIFF_W-1:0]  cell_d [NB];
   logic signed [DIFF_W-1:0]  d_calc;
   logic signed [32:0]        msum;
   logic signed [53:0]        prod;
   logic signed [52:0]        tdiag;
   logic [63:0]               t_mag;
   logic [DIFF_W-1:0]         d_mag;
   logic signed [63:0]        acc_base, acc_sum;
   logic                      ovf;
   logic                      last;
   logic                      slot_free;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign nb = (bc_ff == '0) ? BC_W'(1) : ((32'(bc_ff) > NB) ? BC_W'(NB) : bc_ff);
   assign last = ({1'b0, k_ff} == nb - BC_W'(1));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign jn = (32'(j_ff) == NB - 1) ? '0 : RW'(32'(j_ff) + 1);

   assign mean_we = req_take && (req_data.func == FUNC_MEAN) && (32'(req_data.row_index) < NB);
   assign cov_we  = req_take && (req_data.func == FUNC_COV) &&
                    (32'(req_data.row_index) < NB) && (32'(req_data.col_index) < NB);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.func == FUNC_SAMPLE) &&
                ({1'b0, req_data.row_index} < nb)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF:  state_in = ST_DIAG;
         ST_DIAG:  state_in = ST_MAC;
         ST_MAC: begin
            if (32'(j_ff) == NB - 1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MLO;
         ST_MLO:   state_in = ST_MHI;
         ST_MHI:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_OUT;
         ST_OUT: begin
            if (!last || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ra_r    = k_ff[RW-1:0];
      ra_c    = k_ff[RW-1:0];
      mean_ra = k_ff[RW-1:0];
      j_in    = j_ff;
      for (int i = 0; i < NB; i++) begin
         cell_ctrl[i].load  = (state_ff == ST_DIFF) && (32'(k_ff) == i);
         cell_ctrl[i].shift = (state_ff == ST_MAC);
      end
      unique case (state_ff)
         ST_IDLE: begin
            ra_r    = req_data.row_index[RW-1:0];
            ra_c    = req_data.row_index[RW-1:0];
            mean_ra = req_data.row_index[RW-1:0];
         end
         ST_DIAG: begin
            ra_c = '0;
            j_in = '0;
         end
         ST_MAC: begin
            ra_c = jn;
            j_in = jn;
         end
         default: begin
         end
      endcase
   end

   rxas_ram #(.WIDTH(MEAN_W), .DEPTH(NB)) u_mean_ram (
      .clock     (clock),
      .wr_en     (mean_we),
      .wr_addr   (req_data.row_index[RW-1:0]),
      .wr_data   (req_data.value[MEAN_W-1:0]),
      .rd_addr_a (mean_ra),
      .rd_data_a (mean_rd),
      .rd_addr_b (mean_ra),
      .rd_data_b ()
   );

   rxas_ram #(.WIDTH(COEF_W), .DEPTH(NB * NB)) u_cov_ram (
      .clock     (clock),
      .wr_en     (cov_we),
      .wr_addr   (cov_addr(req_data.row_index[RW-1:0], req_data.col_index[RW-1:0])),
      .wr_data   (req_data.value),
      .rd_addr_a (cov_addr(ra_r, ra_c)),
      .rd_data_a (cov_rd_a),
      .rd_addr_b (cov_addr(ra_c, ra_r)),
      .rd_data_b (cov_rd_b)
   );

   assign d_calc = $signed({1'b0, s_ff, 4'b0000}) - $signed({1'b0, mean_rd});

   for (genvar i = 0; i < NB; i++) begin : g_cell
      rxas_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .load_data (d_calc),
         .from_next (cell_d[(i + 1) % NB]),
         .diff      (cell_d[i])
      );
   end

   assign msum  = $signed({cov_rd_a[COEF_W-1], cov_rd_a}) +
                  $signed({cov_rd_b[COEF_W-1], cov_rd_b});
   assign prod  = msum * cell_d[0];
   assign tdiag = $signed(cov_rd_a) * d_ff;
   assign t_mag = t_ff[63] ? 64'(-t_ff) : t_ff;
   assign d_mag = d_ff[DIFF_W-1] ? DIFF_W'(-d_ff) : d_ff;

   assign acc_base = (k_ff == '0) ? '0 : acc_ff;
   assign acc_sum  = acc_base + v_ff;
   assign ovf      = (acc_base[63] == v_ff[63]) && (acc_sum[63] != acc_base[63]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bc_ff        <= BC_RESET;
         acc_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            bc_ff <= csr_data;
         end
         pv_ff <= (state_ff == ST_MAC) && (32'(j_ff) < 32'(k_ff));
         if (state_ff == ST_ACC) begin
            flag_ff <= ((k_ff == '0) ? 1'b0 : flag_ff) || ovf;
            if (ovf) begin
               acc_ff <= acc_base[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
               acc_ff <= acc_sum;
            end
         end
         if ((state_ff == ST_OUT) && last && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      p_ff <= {{10{prod[53]}}, prod};
      if (state_ff == ST_IDLE) begin
         k_ff <= req_data.row_index;
         if (req_data.value < 0) begin
            s_ff <= '0;
         end else if (req_data.value > 32'sd65535) begin
            s_ff <= 16'hFFFF;
         end else begin
            s_ff <= req_data.value[15:0];
         end
      end
      if (state_ff == ST_DIFF) begin
         d_ff <= d_calc;
      end
      if (state_ff == ST_DIAG) begin
         t_ff <= {{11{tdiag[52]}}, tdiag};
      end else if (((state_ff == ST_MAC) || (state_ff == ST_DRAIN)) && pv_ff) begin
         t_ff <= t_ff + p_ff;
      end
      if (state_ff == ST_MLO) begin
         mlo_ff <= (64'(t_mag[31:0]) * 64'(d_mag)) >> 16;
      end
      if (state_ff == ST_MHI) begin
         mhi_ff <= (64'(t_mag[57:32]) * 64'(d_mag)) << 16;
      end
      if (state_ff == ST_SUM) begin
         if (t_ff[63] != d_ff[DIFF_W-1]) begin
            v_ff <= -$signed(mhi_ff + mlo_ff);
         end else begin
            v_ff <= $signed(mhi_ff + mlo_ff);
         end
      end
      if ((state_ff == ST_OUT) && last && slot_free) begin
         if (acc_ff[63]) begin
            rsp_ff.score     <= '0;
            rsp_ff.saturated <= flag_ff;
         end else if (acc_ff[62:SCORE_W] != '0) begin
            rsp_ff.score     <= '1;
            rsp_ff.saturated <= 1'b1;
         end else begin
            rsp_ff.score     <= acc_ff[SCORE_W-1:0];
            rsp_ff.saturated <= flag_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/rxas_checker.sv -----
// ----------------------------------------------------------------------------
// rxas_checker
// Port-level checks for the RX anomaly score block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rxas_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire rxas_pkg::req_type         req_data,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire rxas_pkg::rsp_type         rsp_data
);
   import rxas_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result word dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("Result word changed while stalled.");

   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.func == FUNC_MEAN || req_data.func == FUNC_COV) |=> !req_stall)
      else $error("Table write word did not complete in one cycle.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result word present after reset.");

endmodule

bind rx_anomaly_score rxas_checker u_rxas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
